### hdl/multiset_intersection_counter_macros.svh
// Assertion macros for the multiset intersection counter.
// Expect signals named clock and reset in the including module.
`ifndef MULTISET_INTERSECTION_COUNTER_MACROS_SVH
`define MULTISET_INTERSECTION_COUNTER_MACROS_SVH

`define MSIC_ASSERT_ALWAYS(name, expr, msg) \
   name: assert property (@(posedge clock) disable iff (reset) (expr)) else $error(msg);

`define MSIC_ASSERT_SAME(name, ante, cons, msg) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) else $error(msg);

`define MSIC_ASSERT_NEXT(name, ante, cons, msg) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) else $error(msg);

`endif

### hdl/msic_pkg.sv
// Shared types and constants for the multiset intersection counter.
// No dependencies.
package msic_pkg;

   localparam int KEY_BITS = 32;
   localparam int USER_BITS = 2;
   localparam int HASH_CNT_BITS = 2;
   localparam logic [HASH_CNT_BITS-1:0] HASH_MUL = 2'd0;
   localparam logic [HASH_CNT_BITS-1:0] HASH_ADJ = 2'd1;
   localparam logic [HASH_CNT_BITS-1:0] HASH_LAST = 2'd2;

   localparam logic OP_LOAD = 1'b0;
   localparam logic OP_PROBE = 1'b1;

   typedef enum logic [2:0] {
      S_WIPE_RESET,
      S_IDLE,
      S_WIPE_ITEM,
      S_HASH,
      S_READ,
      S_CHECK,
      S_DONE
   } state_type;

   typedef struct packed {
      logic load;
      logic wipe;
      logic hash_step;
      logic rd_issue;
      logic advance;
      logic finish;
   } cmd_type;

   typedef struct packed {
      logic wipe_last;
      logic hash_done;
      logic slot_stop;
      logic out_free;
   } status_type;

endpackage

### hdl/msic_controller.sv
// Sequencer for the multiset intersection counter: wipe, hash, probe, finish.
// Depends on msic_pkg.
module msic_controller (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_tvalid,
   input  logic                 req_new_set,
   output logic                 req_tready,
   input  msic_pkg::status_type status,
   output msic_pkg::cmd_type    cmd
);
   import msic_pkg::*;

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_WIPE_RESET;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      cmd = '0;
      req_tready = 1'b0;
      case (state_ff)
         S_WIPE_RESET: begin
            cmd.wipe = 1'b1;
            if (status.wipe_last) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.load = 1'b1;
               state_in = req_new_set ? S_WIPE_ITEM : S_HASH;
            end
         end
         S_WIPE_ITEM: begin
            cmd.wipe = 1'b1;
            if (status.wipe_last) begin
               state_in = S_HASH;
            end
         end
         S_HASH: begin
            cmd.hash_step = 1'b1;
            if (status.hash_done) begin
               state_in = S_READ;
            end
         end
         S_READ: begin
            cmd.rd_issue = 1'b1;
            state_in = S_CHECK;
         end
         S_CHECK: begin
            if (status.slot_stop) begin
               state_in = S_DONE;
            end else begin
               cmd.advance = 1'b1;
            end
         end
         S_DONE: begin
            if (status.out_free) begin
               cmd.finish = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_WIPE_RESET;
         end
      endcase
   end

endmodule

### hdl/msic_datapath.sv
// Datapath of the multiset intersection counter: item registers, hash,
// slot table memory, probe counters and result register. Depends on msic_pkg.
module msic_datapath #(
   parameter int TABLE_ENTRIES = 256,
   parameter int COUNT_BITS = 16
) (
   input  logic                              clock,
   input  logic                              reset,
   input  msic_pkg::cmd_type                 cmd,
   output msic_pkg::status_type              status,
   input  logic                              req_op,
   input  logic [msic_pkg::KEY_BITS-1:0]     req_tdata,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [msic_pkg::KEY_BITS-1:0]     rsp_tdata,
   output logic [msic_pkg::USER_BITS-1:0]    rsp_tuser
);
   import msic_pkg::*;

   localparam int IDX_W = $clog2(TABLE_ENTRIES);
   localparam int WORD_W = 1 + COUNT_BITS + KEY_BITS;
   localparam bit POW2 = (TABLE_ENTRIES & (TABLE_ENTRIES - 1)) == 0;
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_ENTRIES - 1);
   localparam logic [COUNT_BITS-1:0] CNT_MAX = '1;
   localparam logic [COUNT_BITS-1:0] CNT_ONE = COUNT_BITS'(1);
   localparam longint unsigned N_WIDE = longint'(TABLE_ENTRIES);
   localparam longint unsigned SPAN = 64'd1 << IDX_W;
   localparam logic [KEY_BITS-1:0] RECIP =
      KEY_BITS'((((SPAN - N_WIDE) << KEY_BITS) / N_WIDE) + 64'd1);
   localparam logic [KEY_BITS-1:0] DIVISOR = KEY_BITS'(TABLE_ENTRIES);
   localparam int POST_SHIFT = IDX_W - 1;

   logic [WORD_W-1:0] mem [TABLE_ENTRIES];
   logic [WORD_W-1:0] rd_ff;

   logic                     op_ff, op_in;
   logic [KEY_BITS-1:0]      key_ff, key_in;
   logic [IDX_W-1:0]         pos_ff, pos_in;
   logic [IDX_W-1:0]         probe_ff, probe_in;
   logic [IDX_W-1:0]         wipe_ff, wipe_in;
   logic [HASH_CNT_BITS-1:0] hash_cnt_ff, hash_cnt_in;
   logic [KEY_BITS-1:0]      quo_ff, quo_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   logic                     hit_ff, hit_in;
   logic                     full_ff, full_in;
   logic [KEY_BITS-1:0]      value_ff, value_in;

   logic [IDX_W-1:0]         pos_next;
   logic [2*KEY_BITS-1:0]    recip_prod;
   logic [KEY_BITS-1:0]      quo_half;
   logic [KEY_BITS-1:0]      rem_full;
   logic [IDX_W-1:0]         rd_addr;
   logic                     rd_en;
   logic                     wr_en;
   logic [IDX_W-1:0]         wr_addr;
   logic [WORD_W-1:0]        wr_data;
   logic                     slot_valid;
   logic [COUNT_BITS-1:0]    slot_cnt;
   logic [KEY_BITS-1:0]      slot_key;
   logic                     found;
   logic                     fin_wr;
   logic [COUNT_BITS-1:0]    fin_cnt;

   assign slot_valid = rd_ff[WORD_W-1];
   assign slot_cnt = rd_ff[KEY_BITS +: COUNT_BITS];
   assign slot_key = rd_ff[KEY_BITS-1:0];
   assign found = slot_valid && (slot_key == key_ff);
   assign pos_next = (pos_ff == LAST_IDX) ? '0 : pos_ff + 1'b1;

   // home slot by reciprocal multiplication: multiply, adjust and shift, remainder
   assign recip_prod = (2*KEY_BITS)'(key_ff) * (2*KEY_BITS)'(RECIP);
   assign quo_half = quo_ff + ((key_ff - quo_ff) >> 1);
   assign rem_full = key_ff - KEY_BITS'(quo_ff * DIVISOR);

   always_comb begin
      fin_wr = 1'b0;
      fin_cnt = slot_cnt;
      hit_in = hit_ff;
      full_in = full_ff;
      value_in = value_ff;
      if (cmd.finish) begin
         hit_in = 1'b0;
         full_in = 1'b0;
         value_in = '0;
         if (op_ff == OP_LOAD) begin
            if (found) begin
               fin_wr = 1'b1;
               fin_cnt = (slot_cnt == CNT_MAX) ? slot_cnt : slot_cnt + 1'b1;
            end else if (!slot_valid) begin
               fin_wr = 1'b1;
               fin_cnt = CNT_ONE;
            end else begin
               full_in = 1'b1;
            end
         end else begin
            if (found && (slot_cnt != '0)) begin
               fin_wr = 1'b1;
               fin_cnt = slot_cnt - 1'b1;
               hit_in = 1'b1;
               value_in = key_ff;
            end
         end
      end
   end

   always_comb begin
      wr_en = 1'b0;
      wr_addr = pos_ff;
      wr_data = {1'b1, fin_cnt, key_ff};
      if (cmd.wipe) begin
         wr_en = 1'b1;
         wr_addr = wipe_ff;
         wr_data = '0;
      end else if (fin_wr) begin
         wr_en = 1'b1;
      end
   end

   assign rd_en = cmd.rd_issue | cmd.advance;
   assign rd_addr = cmd.advance ? pos_next : pos_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_ff <= mem[rd_addr];
      end
   end

   always_comb begin
      op_in = op_ff;
      key_in = key_ff;
      pos_in = pos_ff;
      probe_in = probe_ff;
      hash_cnt_in = hash_cnt_ff;
      quo_in = quo_ff;
      if (cmd.load) begin
         op_in = req_op;
         key_in = req_tdata;
         pos_in = '0;
         probe_in = '0;
         hash_cnt_in = '0;
      end else if (cmd.hash_step) begin
         hash_cnt_in = hash_cnt_ff + 1'b1;
         if (POW2) begin
            pos_in = key_ff[IDX_W-1:0];
         end else begin
            case (hash_cnt_ff)
               HASH_MUL: begin
                  quo_in = recip_prod[2*KEY_BITS-1:KEY_BITS];
               end
               HASH_ADJ: begin
                  quo_in = quo_half >> POST_SHIFT;
               end
               default: begin
                  pos_in = rem_full[IDX_W-1:0];
               end
            endcase
         end
      end else if (cmd.advance) begin
         pos_in = pos_next;
         probe_in = probe_ff + 1'b1;
      end
   end

   assign wipe_in = !cmd.wipe ? wipe_ff : (wipe_ff == LAST_IDX) ? '0 : wipe_ff + 1'b1;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.finish) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      op_ff <= op_in;
      key_ff <= key_in;
      quo_ff <= quo_in;
      hit_ff <= hit_in;
      full_ff <= full_in;
      value_ff <= value_in;
      if (reset) begin
         pos_ff <= '0;
         probe_ff <= '0;
         wipe_ff <= '0;
         hash_cnt_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         pos_ff <= pos_in;
         probe_ff <= probe_in;
         wipe_ff <= wipe_in;
         hash_cnt_ff <= hash_cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign status.wipe_last = (wipe_ff == LAST_IDX);
   assign status.hash_done = POW2 || (hash_cnt_ff == HASH_LAST);
   assign status.slot_stop = !slot_valid || found || (probe_ff == LAST_IDX);
   assign status.out_free = !rsp_valid_ff || rsp_tready;

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata = value_ff;
   assign rsp_tuser = {full_ff, hit_ff};

endmodule

### hdl/multiset_intersection_counter.sv
// Top level of the multiset intersection counter: controller plus datapath.
// Depends on msic_pkg, msic_controller, msic_datapath and the macro header.
//
//   channel  direction  tdata           tuser
//   req      in         item_value      [0] op, [1] new_set
//   rsp      out        common_value    [0] hit, [1] table_full
//
// Each transaction runs accept, hash (three steps when TABLE_ENTRIES is not a
// power of two), read, one check per slot probed and finish; probing is paced
// by the single read port of the slot table.
// After reset the whole table is wiped before req_tready rises.
// new_set adds a wipe of the whole table. A stalled result holds the
// finish step; the next transaction is accepted while a result waits.
`include "multiset_intersection_counter_macros.svh"

module multiset_intersection_counter #(
   parameter int TABLE_ENTRIES = 256,
   parameter int COUNT_BITS = 16
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_tvalid,
   output logic                           req_tready,
   input  logic [msic_pkg::KEY_BITS-1:0]  req_tdata,  // [31:0] item_value
   input  logic [msic_pkg::USER_BITS-1:0] req_tuser,  // [0] op, [1] new_set
   output logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   output logic [msic_pkg::KEY_BITS-1:0]  rsp_tdata,  // [31:0] common_value
   output logic [msic_pkg::USER_BITS-1:0] rsp_tuser   // [0] hit, [1] table_full
);
   import msic_pkg::*;

   cmd_type    cmd;
   status_type status;

   msic_controller u_controller (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_new_set (req_tuser[1]),
      .req_tready  (req_tready),
      .status      (status),
      .cmd         (cmd)
   );

   msic_datapath #(
      .TABLE_ENTRIES (TABLE_ENTRIES),
      .COUNT_BITS    (COUNT_BITS)
   ) u_datapath (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .status     (status),
      .req_op     (req_tuser[0]),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   `MSIC_ASSERT_SAME(a_finish_free, cmd.finish, status.out_free, "result overwritten")
   `MSIC_ASSERT_ALWAYS(a_cmd_onehot, $onehot0(cmd), "conflicting datapath commands")
   `MSIC_ASSERT_NEXT(a_one_item, req_tvalid && req_tready, !req_tready, "second item taken")

endmodule

### tb/tb_multiset_intersection_counter.sv
`timescale 1ns / 1ps
// Self-checking testbench for multiset_intersection_counter: stream stimulus with
// random gaps and back-pressure, checked against a count-table scoreboard class.
// Depends on msic_pkg and the multiset_intersection_counter RTL.
module tb_multiset_intersection_counter;
   import msic_pkg::*;

   localparam int ENTRIES = 256;
   localparam int COUNT_BITS = 16;
   localparam int STALL_LIMIT = 5000;
   localparam int HOLD_CYCLES = 600;
   localparam int DRAIN_CYCLES = 600;
   localparam int RANDOM_ITEMS = 1400;

   typedef struct packed {
      logic        hit;
      logic [31:0] common_value;
      logic        table_full;
   } match_result_type;

   class intersect_scoreboard_type;
      logic [31:0]           slot_key   [ENTRIES];
      logic [COUNT_BITS-1:0] slot_count [ENTRIES];
      bit                    slot_used  [ENTRIES];
      match_result_type      expected_matches [$];
      int                    errors;

      function new();
         errors = 0;
         foreach (slot_used[i]) slot_used[i] = 1'b0;
      endfunction

      function void predict_item(logic op, logic [31:0] key, logic clr);
         int pos;
         int found;
         int free_pos;
         match_result_type r;
         if (clr) begin
            foreach (slot_used[i]) slot_used[i] = 1'b0;
         end
         found = -1;
         free_pos = -1;
         pos = int'(key % 32'(ENTRIES));
         for (int n = 0; n < ENTRIES; n++) begin
            if (!slot_used[pos]) begin
               free_pos = pos;
               break;
            end
            if (slot_key[pos] == key) begin
               found = pos;
               break;
            end
            pos = (pos + 1) % ENTRIES;
         end
         r = '0;
         if (op == OP_LOAD) begin
            if (found >= 0) begin
               if (slot_count[found] != {COUNT_BITS{1'b1}}) slot_count[found]++;
            end else if (free_pos >= 0) begin
               slot_key[free_pos] = key;
               slot_count[free_pos] = COUNT_BITS'(1);
               slot_used[free_pos] = 1'b1;
            end else begin
               r.table_full = 1'b1;
            end
         end else if (found >= 0 && slot_count[found] != 0) begin
            slot_count[found]--;
            r.hit = 1'b1;
            r.common_value = key;
         end
         expected_matches = {expected_matches, r};
      endfunction

      task report_mismatch(string what, logic [31:0] got, logic [31:0] want);
         $display("mismatch %s: got %h, want %h", what, got, want);
         errors++;
      endtask

      task check_result(logic hit, logic [31:0] value, logic full);
         match_result_type want;
         if (expected_matches.size() == 0) begin
            report_mismatch("result with nothing expected", value, 32'h0);
            return;
         end
         want = expected_matches.pop_front();
         if (hit !== want.hit) report_mismatch("hit", 32'(hit), 32'(want.hit));
         if (value !== want.common_value)
            report_mismatch("common_value", value, want.common_value);
         if (full !== want.table_full)
            report_mismatch("table_full", 32'(full), 32'(want.table_full));
      endtask
   endclass

   logic                 clock;
   logic                 reset = 1'b1;
   logic                 req_tvalid = 1'b0;
   logic                 req_tready;
   logic [KEY_BITS-1:0]  req_tdata = '0;   // [31:0] item_value
   logic [USER_BITS-1:0] req_tuser = '0;   // [0] op, [1] new_set
   logic                 rsp_tvalid;
   logic                 rsp_tready = 1'b0;
   logic [KEY_BITS-1:0]  rsp_tdata;        // [31:0] common_value
   logic [USER_BITS-1:0] rsp_tuser;        // [0] hit, [1] table_full

   bit steady = 1'b0;
   bit squeeze_now = 1'b0;
   int items_sent = 0;
   int stall_cycles = 0;
   int hold_left = 0;

   intersect_scoreboard_type sb = new();

   multiset_intersection_counter #(
      .TABLE_ENTRIES(ENTRIES),
      .COUNT_BITS(COUNT_BITS)
   ) dut (
      .clock(clock),
      .reset(reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata(req_tdata),
      .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata),
      .rsp_tuser(rsp_tuser)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   task automatic send_item(input logic op, input logic [31:0] value, input logic clr);
      while (!steady && $urandom_range(99) < 26) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= value;
      req_tuser <= {clr, op};
      do @(posedge clock); while (!req_tready);
      sb.predict_item(op, value, clr);
      items_sent++;
      @(negedge clock);
   endtask

   function automatic logic [31:0] pick_value();
      logic [31:0] extremes [6] = '{32'h0, 32'h1, 32'h7FFF_FFFF, 32'h8000_0000,
                                    32'hFFFF_FFFF, 32'h0000_00FF};
      case ($urandom_range(3))
         0: return $urandom;
         1: return ($urandom & ~32'(ENTRIES - 1)) | 32'($urandom_range(3));
         2: return extremes[$urandom_range(5)];
         default: return 32'($urandom_range(600));
      endcase
   endfunction

   // receiver: random back-pressure, one long hold-off on request
   always @(negedge clock) begin
      if (hold_left > 0) begin
         hold_left <= hold_left - 1;
         rsp_tready <= 1'b0;
      end else if (squeeze_now) begin
         squeeze_now = 1'b0;
         hold_left <= HOLD_CYCLES;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= steady || ($urandom_range(99) >= 26);
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready)
         sb.check_result(rsp_tuser[0], rsp_tdata, rsp_tuser[1]);
   end

   initial begin
      while (stall_cycles < STALL_LIMIT) begin
         @(posedge clock);
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
            stall_cycles = 0;
         else
            stall_cycles++;
      end
      $display("TB_ERROR");
      $finish;
   end

   initial begin
      logic [31:0] fill_keys [ENTRIES];
      logic [31:0] pool [16];
      logic [31:0] v;
      int pool_size;
      int n_load;
      int n_probe;
      int start;

      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed: extremes, collisions with wrap, exhausted and absent values, new_set
      send_item(OP_LOAD,  32'h0000_0000, 1'b1);
      send_item(OP_LOAD,  32'h7FFF_FFFF, 1'b0);
      send_item(OP_LOAD,  32'h8000_0000, 1'b0);
      send_item(OP_LOAD,  32'hFFFF_FFFF, 1'b0);
      send_item(OP_LOAD,  32'h7FFF_FFFF, 1'b0);
      send_item(OP_PROBE, 32'h0000_0000, 1'b0);
      send_item(OP_PROBE, 32'h0000_0000, 1'b0);
      send_item(OP_PROBE, 32'h7FFF_FFFF, 1'b0);
      send_item(OP_PROBE, 32'h7FFF_FFFF, 1'b0);
      send_item(OP_PROBE, 32'h7FFF_FFFF, 1'b0);
      send_item(OP_PROBE, 32'hFFFF_FFFF, 1'b0);
      send_item(OP_PROBE, 32'h8000_0000, 1'b0);
      send_item(OP_PROBE, 32'h1234_5678, 1'b0);
      send_item(OP_LOAD,  32'h0000_0100, 1'b0);
      send_item(OP_PROBE, 32'h0000_0100, 1'b0);
      send_item(OP_PROBE, 32'h0000_0200, 1'b0);
      send_item(OP_LOAD,  32'h0000_0000, 1'b0);
      send_item(OP_PROBE, 32'h0000_0000, 1'b0);
      send_item(OP_PROBE, 32'hFFFF_FFFF, 1'b1);
      send_item(OP_LOAD,  32'hAAAA_AAAA, 1'b1);
      send_item(OP_PROBE, 32'h5555_5555, 1'b0);
      send_item(OP_PROBE, 32'hAAAA_AAAA, 1'b0);
      send_item(OP_LOAD,  32'h5555_5555, 1'b1);
      send_item(OP_PROBE, 32'h5555_5555, 1'b0);

      // fill every slot, then overflow and search a full table
      for (int i = 0; i < ENTRIES; i++) begin
         v = ($urandom & ~32'(ENTRIES - 1)) | 32'(i);
         fill_keys[i] = v;
         send_item(OP_LOAD, v, i == 0);
      end
      for (int i = 0; i < 4; i++) send_item(OP_LOAD, $urandom, 1'b0);
      send_item(OP_LOAD, fill_keys[5], 1'b0);
      send_item(OP_PROBE, fill_keys[5], 1'b0);
      send_item(OP_PROBE, fill_keys[5], 1'b0);
      send_item(OP_PROBE, fill_keys[5], 1'b0);
      send_item(OP_PROBE, fill_keys[ENTRIES-1], 1'b0);
      send_item(OP_PROBE, $urandom, 1'b0);
      send_item(OP_PROBE, $urandom, 1'b0);
      send_item(OP_LOAD, fill_keys[ENTRIES-1], 1'b0);

      // random sets: mostly load-then-probe sequences, some noise and broken sets
      start = items_sent;
      squeeze_now = 1'b1;
      while (items_sent - start < RANDOM_ITEMS) begin
         steady = (items_sent - start >= 700) && (items_sent - start < 1000);
         pool_size = $urandom_range(16, 2);
         for (int i = 0; i < pool_size; i++) pool[i] = pick_value();
         n_load = ($urandom_range(9) == 0) ? 0 : $urandom_range(30, 1);
         n_probe = $urandom_range(30, 1);
         for (int k = 0; k < n_load + n_probe; k++) begin
            if ($urandom_range(9) == 0)
               send_item(1'($urandom), $urandom, $urandom_range(49) == 0);
            else
               send_item(k < n_load ? OP_LOAD : OP_PROBE,
                         ($urandom_range(7) == 0) ? pick_value()
                                                  : pool[$urandom_range(pool_size - 1)],
                         k == 0);
         end
      end
      steady = 1'b0;
      req_tvalid <= 1'b0;

      while (sb.expected_matches.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (sb.errors == 0)
         $display("TB_OK");
      else
         $display("TB_ERROR");
      $finish;
   end
endmodule

### sim.f
+incdir+hdl
hdl/msic_pkg.sv
hdl/msic_controller.sv
hdl/msic_datapath.sv
hdl/multiset_intersection_counter.sv
tb/tb_multiset_intersection_counter.sv
